// ----- rtl/jsd_pkg.sv -----
package jsd_pkg;

    // Field and register widths
    localparam int FIELD_W   = 17;
    localparam int BATCH_W   = 11;
    localparam int LOSS_W    = 32;
    localparam int TDATA_W   = 40;

    // log2 unit: input up to p+q, result e.f in Q.24
    localparam int X_W       = FIELD_W + 1;
    localparam int E_W       = 5;
    localparam int FRAC_W    = 24;
    localparam int LOG_W     = E_W + FRAC_W;
    localparam int M_W       = 32;
    localparam int STEP_W    = 5;

    // Pair term datapath
    localparam int D_W       = 31;
    localparam int PROD_W    = FIELD_W + 1 + D_W;
    localparam int A_W       = PROD_W + 1;
    localparam int SHIFT_W   = 40;
    localparam int TERM_W    = 40;
    localparam int SUM_W     = 65;
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam int SCALE_SH  = 17;
    localparam int LOSS_SH   = 8;

    // Register indexes
    localparam logic REG_MIN_EPS     = 1'b0;
    localparam logic REG_BATCH_COUNT = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] q;
        logic               last;
        logic               hit;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOG,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_ACC,
        S_DLOAD,
        S_DIV
    } t_state;

endpackage

// ----- rtl/js_divergence_loss_accumulator_top.sv -----
// A counted pair takes three log2 runs (p, q, p+q), then multiply, sum, scale and
// accumulate; a pair with p or q at or below min_eps is popped uncounted. The last
// beat adds a divider load and a bit-serial divide before the loss appears.
// Throughput is set by the shared iterative log2 unit, which serves one pair at a time.
// Reset (synchronous, active low) clears the sum, queue and output; min_eps and
// batch_count return to 1.
module js_divergence_loss_accumulator_top #(
    parameter int ACC_WIDTH = 48,
    parameter int PROB_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [jsd_pkg::TDATA_W-1:0]   s_axis_tdata,  // p[16:0], q[33:17], zero pad
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [jsd_pkg::LOSS_W-1:0]    m_axis_tdata,  // loss[31:0]
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [jsd_pkg::FIELD_W-1:0]   i_cfg_wdata
);
    logic [jsd_pkg::FIELD_W-1:0] r_min_eps;
    logic [jsd_pkg::BATCH_W-1:0] r_batch_count;
    logic                        q_valid, q_pop;
    jsd_pkg::t_item              q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_eps     <= jsd_pkg::FIELD_W'(1);
            r_batch_count <= jsd_pkg::BATCH_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                jsd_pkg::REG_MIN_EPS:     r_min_eps     <= i_cfg_wdata;
                jsd_pkg::REG_BATCH_COUNT: r_batch_count <= i_cfg_wdata[jsd_pkg::BATCH_W-1:0];
                default: ;
            endcase
        end
    end

    jsd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_p       (s_axis_tdata[jsd_pkg::FIELD_W-1:0]),
        .i_q       (s_axis_tdata[2*jsd_pkg::FIELD_W-1:jsd_pkg::FIELD_W]),
        .i_last    (s_axis_tlast),
        .i_min_eps (r_min_eps),
        .o_valid   (q_valid),
        .o_item    (q_item),
        .i_pop     (q_pop)
    );

    jsd_back #(.ACC_WIDTH(ACC_WIDTH), .PROB_BITS(PROB_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .i_batch_count (r_batch_count),
        .o_valid       (m_axis_tvalid),
        .o_loss        (m_axis_tdata),
        .i_ready       (m_axis_tready)
    );

endmodule

// ----- rtl/jsd_front.sv -----
module jsd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [jsd_pkg::FIELD_W-1:0]   i_p,
    input  logic [jsd_pkg::FIELD_W-1:0]   i_q,
    input  logic                          i_last,
    input  logic [jsd_pkg::FIELD_W-1:0]   i_min_eps,
    output logic                          o_valid,
    output jsd_pkg::t_item                o_item,
    input  logic                          i_pop
);
    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    jsd_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             push;
    jsd_pkg::t_item   item;

    // classify the beat
    always_comb begin
        item.p    = i_p;
        item.q    = i_q;
        item.last = i_last;
        item.hit  = (i_p > i_min_eps) && (i_q > i_min_eps);
    end

    assign o_ready = (r_cnt != (PTR_W+1)'(DEPTH));
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = push  ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= item;
        end
    end

endmodule

// ----- rtl/jsd_log2.sv -----
module jsd_log2 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [jsd_pkg::X_W-1:0]      i_x,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [jsd_pkg::LOG_W-1:0]    o_log
);
    logic [jsd_pkg::M_W-1:0]    r_m, n_m;
    logic [jsd_pkg::FRAC_W-1:0] r_f;
    logic [jsd_pkg::E_W-1:0]    r_e, e;
    logic [jsd_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy, r_done;
    logic [2*jsd_pkg::M_W-1:0]  prod;
    logic [jsd_pkg::M_W:0]      sq;
    logic                       bit_f;

    // integer part: index of the top set bit
    always_comb begin
        e = '0;
        for (int i = 0; i < jsd_pkg::X_W; i++) begin
            if (i_x[i]) e = jsd_pkg::E_W'(i);
        end
    end

    // one squaring of the mantissa per cycle
    always_comb begin
        prod  = 64'(r_m) * 64'(r_m);
        sq    = prod[2*jsd_pkg::M_W-1:jsd_pkg::M_W-1];
        bit_f = sq[jsd_pkg::M_W];
        n_m   = bit_f ? sq[jsd_pkg::M_W:1] : sq[jsd_pkg::M_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == jsd_pkg::STEP_W'(jsd_pkg::FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m <= jsd_pkg::M_W'(i_x) << (jsd_pkg::E_W'(jsd_pkg::M_W - 1) - e);
            r_e <= e;
            r_f <= '0;
        end else if (r_busy) begin
            r_m <= n_m;
            r_f <= {r_f[jsd_pkg::FRAC_W-2:0], bit_f};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_log  = {r_e, r_f};

endmodule

// ----- rtl/jsd_div.sv -----
module jsd_div #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ACC_WIDTH-1:0]          i_dividend,
    input  logic [jsd_pkg::BATCH_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [ACC_WIDTH-1:0]          o_quot
);
    localparam int CNT_W = $clog2(ACC_WIDTH + 1);

    logic [ACC_WIDTH-1:0]          r_quo;
    logic [jsd_pkg::BATCH_W-1:0]   r_rem, r_div;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy, r_done;
    logic [jsd_pkg::BATCH_W:0]     trial;
    logic                          take;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quo[ACC_WIDTH-1]};
        take  = (trial >= (jsd_pkg::BATCH_W+1)'(r_div));
    end

    // done stays high with the quotient until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= (i_divisor == '0) ? jsd_pkg::BATCH_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? jsd_pkg::BATCH_W'(trial - (jsd_pkg::BATCH_W+1)'(r_div))
                          : trial[jsd_pkg::BATCH_W-1:0];
            r_quo <= {r_quo[ACC_WIDTH-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- rtl/jsd_back.sv -----
module jsd_back #(
    parameter int ACC_WIDTH = 48,
    parameter int PROB_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  jsd_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic [jsd_pkg::BATCH_W-1:0]   i_batch_count,
    output logic                          o_valid,
    output logic [jsd_pkg::LOSS_W-1:0]    o_loss,
    input  logic                          i_ready
);
    localparam logic [jsd_pkg::D_W-1:0] ONE_Q24 = jsd_pkg::D_W'(1) << jsd_pkg::FRAC_W;
    localparam logic [jsd_pkg::SUM_W-1:0] ACC_MAX =
        (jsd_pkg::SUM_W'(1) << ACC_WIDTH) - 1'b1;

    jsd_pkg::t_state r_state, n_state;
    jsd_pkg::t_item  r_item;
    logic [1:0]                      r_sel;
    logic [jsd_pkg::LOG_W-1:0]       r_lp, r_lq, r_ls;
    logic signed [jsd_pkg::PROD_W-1:0] r_prod_p, r_prod_q;
    logic [jsd_pkg::SHIFT_W-1:0]     r_shift;
    logic [jsd_pkg::TERM_W-1:0]      r_term;
    logic [ACC_WIDTH-1:0]            r_sum;
    logic                            r_out_valid;
    logic [jsd_pkg::LOSS_W-1:0]      r_loss;

    logic                            log_start, log_busy, log_done;
    logic [jsd_pkg::X_W-1:0]         log_x;
    logic [jsd_pkg::LOG_W-1:0]       log_res;
    logic                            div_start, div_done;
    logic [ACC_WIDTH-1:0]            quot;
    logic                            can_load;
    logic signed [jsd_pkg::D_W-1:0]  dp, dq;
    logic signed [jsd_pkg::A_W-1:0]  a;
    logic [jsd_pkg::SUM_W-1:0]       acc;
    logic [63:0]                     loss_wide;

    jsd_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_busy  (log_busy),
        .o_done  (log_done),
        .o_log   (log_res)
    );

    jsd_div #(.ACC_WIDTH(ACC_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (i_batch_count),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign can_load = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jsd_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_item.hit)       n_state = jsd_pkg::S_LOG;
                    else if (i_item.last) n_state = jsd_pkg::S_DLOAD;
                end
            end
            jsd_pkg::S_LOG:   if (log_done && r_sel == 2'd2) n_state = jsd_pkg::S_MUL;
            jsd_pkg::S_MUL:   n_state = jsd_pkg::S_SUM;
            jsd_pkg::S_SUM:   n_state = jsd_pkg::S_SCALE;
            jsd_pkg::S_SCALE: n_state = jsd_pkg::S_ACC;
            jsd_pkg::S_ACC:   n_state = r_item.last ? jsd_pkg::S_DLOAD : jsd_pkg::S_IDLE;
            jsd_pkg::S_DLOAD: n_state = jsd_pkg::S_DIV;
            jsd_pkg::S_DIV:   if (div_done && can_load) n_state = jsd_pkg::S_IDLE;
            default:          n_state = jsd_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        log_start = 1'b0;
        div_start = 1'b0;
        log_x     = jsd_pkg::X_W'(i_item.p);
        case (r_state)
            jsd_pkg::S_IDLE: begin
                o_pop     = i_valid;
                log_start = i_valid && i_item.hit;
            end
            jsd_pkg::S_LOG: begin
                log_start = log_done && (r_sel != 2'd2);
                log_x     = (r_sel == 2'd0) ? jsd_pkg::X_W'(r_item.q)
                          : jsd_pkg::X_W'(r_item.p) + jsd_pkg::X_W'(r_item.q);
            end
            jsd_pkg::S_DLOAD: div_start = 1'b1;
            default: ;
        endcase
    end

    // pair term arithmetic
    always_comb begin
        dp  = $signed(ONE_Q24 + jsd_pkg::D_W'(r_lp) - jsd_pkg::D_W'(r_ls));
        dq  = $signed(ONE_Q24 + jsd_pkg::D_W'(r_lq) - jsd_pkg::D_W'(r_ls));
        a   = jsd_pkg::A_W'(r_prod_p) + jsd_pkg::A_W'(r_prod_q);
        acc = jsd_pkg::SUM_W'(r_sum) + jsd_pkg::SUM_W'(r_term);
        loss_wide = 64'(quot) >> jsd_pkg::LOSS_SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jsd_pkg::S_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_sel       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == jsd_pkg::S_DIV && div_done && can_load) r_out_valid <= 1'b1;
            else if (i_ready)                                     r_out_valid <= 1'b0;
            case (r_state)
                jsd_pkg::S_IDLE:  r_sel <= '0;
                jsd_pkg::S_LOG:   if (log_done) r_sel <= r_sel + 1'b1;
                jsd_pkg::S_ACC:
                    r_sum <= (acc > ACC_MAX) ? ACC_WIDTH'(ACC_MAX) : ACC_WIDTH'(acc);
                jsd_pkg::S_DLOAD: r_sum <= '0;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == jsd_pkg::S_IDLE && i_valid) r_item <= i_item;
        if (r_state == jsd_pkg::S_LOG && log_done) begin
            case (r_sel)
                2'd0:    r_lp <= log_res;
                2'd1:    r_lq <= log_res;
                default: r_ls <= log_res;
            endcase
        end
        if (r_state == jsd_pkg::S_MUL) begin
            r_prod_p <= $signed({1'b0, r_item.p}) * dp;
            r_prod_q <= $signed({1'b0, r_item.q}) * dq;
        end
        if (r_state == jsd_pkg::S_SUM) begin
            r_shift <= (a <= 0) ? '0 : jsd_pkg::SHIFT_W'(a >>> PROB_BITS);
        end
        if (r_state == jsd_pkg::S_SCALE) begin
            r_term <= jsd_pkg::TERM_W'((56'(r_shift) * 56'(jsd_pkg::LN2_Q16))
                                       >> jsd_pkg::SCALE_SH);
        end
        if (r_state == jsd_pkg::S_DIV && div_done && can_load) begin
            r_loss <= (loss_wide[63:32] != '0) ? '1 : loss_wide[31:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_loss  = r_loss;

    // checks
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid) else $error("pop from empty queue");
    a_log_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        log_start |-> !log_busy) else $error("log2 restarted while busy");
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == jsd_pkg::S_DLOAD |=> r_sum == '0) else $error("sum not cleared");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jsd_pkg::S_DIV && div_done && !can_load) |=> r_state == jsd_pkg::S_DIV)
        else $error("result dropped");

endmodule
